// ===== hdl/label_map_region_statistics_unit_assert.svh =====
// Assertion macros for the label map region statistics checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef LABEL_MAP_REGION_STATISTICS_UNIT_ASSERT_SVH
`define LABEL_MAP_REGION_STATISTICS_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define LMRS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmrs: same-cycle property failed");

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define LMRS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmrs: next-cycle property failed");

`endif

// ===== hdl/lmrs_pkg.sv =====
// Shared constants, types and helpers for the label map region statistics unit.
// No dependencies; imported by the top level.
`default_nettype none

package lmrs_pkg;

    localparam int MAX_COMPONENTS = 64;
    localparam int MAX_HEIGHT     = 1024;
    localparam int MAX_WIDTH      = 1024;

    localparam int LABEL_W     = 6;    // pixel label, component index
    localparam int COUNT_W     = 21;   // pixel total
    localparam int COORD_W     = 10;   // box coordinates, positions
    localparam int DIM_W       = 11;   // frame_width / frame_height registers
    localparam int NCOMP_W     = 7;    // component_count register
    localparam int CFG_DATA_W  = 11;   // widest register
    localparam int CFG_INDEX_W = 2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPONENT_COUNT = 2'd2;

    localparam logic [DIM_W-1:0]   WIDTH_RESET  = DIM_W'(1024);
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = DIM_W'(1024);
    localparam logic [NCOMP_W-1:0] NCOMP_RESET  = NCOMP_W'(64);

    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    // One entry of the component memory. adj must stay last (lowest bits):
    // single-bit adjacency writes build their mask by zero extension.
    typedef struct packed {
        logic [COUNT_W-1:0]        count;
        logic [COORD_W-1:0]        min_x;
        logic [COORD_W-1:0]        min_y;
        logic [COORD_W-1:0]        max_x;
        logic [COORD_W-1:0]        max_y;
        logic [MAX_COMPONENTS-1:0] adj;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LINK_PREV,
        ST_LINK_LEFT,
        ST_EMIT_READ,
        ST_EMIT_LOAD
    } state_t;

    function automatic logic [MAX_COMPONENTS-1:0] label_bit(input logic [LABEL_W-1:0] lab);
        logic [MAX_COMPONENTS-1:0] r;
        r      = '0;
        r[lab] = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/label_map_region_statistics_unit.sv =====
// Label map region statistics: per-label pixel count, bounding box and adjacency.
// Depends on lmrs_pkg (constants, entry_t, state_t, label_bit).
//
//  Channel | Handshake              | Payload
//  --------+------------------------+--------------------------------------------
//  in      | in_valid / in_stall    | pixel_label
//  out     | out_valid / out_stall  | component_index .. last_component (9 fields)
//  cfg     | cfg_write              | cfg_index, cfg_data
//
// A pixel passes through accept (memory reads) and then update (stats and own-row write).
// Each reverse adjacency bit (row of the label above / to the left) adds a link state
// with in_stall high, as the component memory has a single write port.
// At frame end each of the component_count results is read, then loaded once the output
// register is free; the component memory is emptied by clearing the per-entry valid bits.
// rst_n is asynchronous; after reset every entry reads empty, the line buffer is
// undefined until its row is written. out_stall holds the output register and the result
// sequence; the next frame's pixels are taken while the final result still waits there.
`default_nettype none

module label_map_region_statistics_unit
    import lmrs_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      cfg_write,
    input  wire logic [CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_data,

    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [LABEL_W-1:0]        pixel_label,

    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [LABEL_W-1:0]             component_index,
    output logic [COUNT_W-1:0]             pixel_total,
    output logic [COORD_W-1:0]             box_min_x,
    output logic [COORD_W-1:0]             box_min_y,
    output logic [COORD_W-1:0]             box_max_x,
    output logic [COORD_W-1:0]             box_max_y,
    output logic [MAX_COMPONENTS-1:0]      neighbour_mask,
    output logic                           bad_label_seen,
    output logic                           last_component
);

    // ------------------------------------------------------------------
    // Configuration registers and their effective (clamped) values
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   width_reg,  width_next;
    logic [DIM_W-1:0]   height_reg, height_next;
    logic [NCOMP_W-1:0] ncomp_reg,  ncomp_next;

    logic [COORD_W-1:0] wm1;     // effective width - 1
    logic [COORD_W-1:0] hm1;     // effective height - 1
    logic [NCOMP_W-1:0] n_eff;   // effective component count, 1..MAX_COMPONENTS

    always_comb begin : cfg_next_logic
        width_next  = width_reg;
        height_next = height_reg;
        ncomp_next  = ncomp_reg;
        if (cfg_write) begin
            if (cfg_index == CFG_FRAME_WIDTH) begin
                width_next = cfg_data;
            end
            if (cfg_index == CFG_FRAME_HEIGHT) begin
                height_next = cfg_data;
            end
            if (cfg_index == CFG_COMPONENT_COUNT) begin
                ncomp_next = cfg_data[NCOMP_W-1:0];
            end
        end
    end

    always_comb begin : cfg_clamp
        priority if (width_reg == '0) begin
            wm1 = '0;
        end else if (width_reg > DIM_W'(MAX_WIDTH)) begin
            wm1 = COORD_W'(MAX_WIDTH - 1);
        end else begin
            wm1 = COORD_W'(width_reg - 1'b1);
        end

        priority if (height_reg == '0) begin
            hm1 = '0;
        end else if (height_reg > DIM_W'(MAX_HEIGHT)) begin
            hm1 = COORD_W'(MAX_HEIGHT - 1);
        end else begin
            hm1 = COORD_W'(height_reg - 1'b1);
        end

        priority if (ncomp_reg == '0) begin
            n_eff = NCOMP_W'(1);
        end else if (ncomp_reg > NCOMP_W'(MAX_COMPONENTS)) begin
            n_eff = NCOMP_W'(MAX_COMPONENTS);
        end else begin
            n_eff = ncomp_reg;
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t                     state_reg, state_next;
    logic [LABEL_W-1:0]         lab_reg, lab_next;           // label of pixel in work
    logic [COORD_W-1:0]         col_reg, col_next;           // column_position
    logic [COORD_W-1:0]         row_reg, row_next;           // row_position
    logic [LABEL_W-1:0]         prev_reg, prev_next;         // previous_label
    logic                       bad_reg, bad_next;           // bad_label_flag
    logic [LABEL_W-1:0]         link_prev_reg, link_prev_next;
    logic [LABEL_W-1:0]         link_left_reg, link_left_next;
    logic                       need_left_reg, need_left_next;
    logic                       frame_end_reg, frame_end_next;
    logic [MAX_COMPONENTS-1:0]  valid_reg, valid_next;       // entry holds this frame's data
    logic [LABEL_W-1:0]         emit_idx_reg, emit_idx_next;

    // ------------------------------------------------------------------
    // Component memory: stats plus adjacency row, per-bit write enable
    // ------------------------------------------------------------------
    entry_t                 ent_mem [MAX_COMPONENTS];
    logic                   mem_we;
    logic [LABEL_W-1:0]     mem_waddr;
    entry_t                 mem_wdata;
    logic [ENTRY_W-1:0]     mem_wmask;
    logic                   mem_re;
    logic [LABEL_W-1:0]     mem_raddr;
    entry_t                 mem_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            for (int b = 0; b < ENTRY_W; b++) begin
                if (mem_wmask[b]) begin
                    ent_mem[mem_waddr][b] <= mem_wdata[b];
                end
            end
        end
        if (mem_re) begin
            mem_rdata_reg <= ent_mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Column line buffer: labels of the previous column, by row
    // ------------------------------------------------------------------
    logic [LABEL_W-1:0]     col_mem [MAX_HEIGHT];
    logic                   col_we;
    logic                   col_re;
    logic [LABEL_W-1:0]     col_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (col_we) begin
            col_mem[row_reg] <= lab_reg;
        end
        if (col_re) begin
            col_rdata_reg <= col_mem[row_reg];
        end
    end

    // ------------------------------------------------------------------
    // Pixel datapath (valid in ST_UPDATE)
    // ------------------------------------------------------------------
    entry_t                 cur_entry;
    entry_t                 upd_entry;
    logic [LABEL_W-1:0]     left_lab;
    logic                   lab_ok, prev_ok, left_ok;
    logic                   vert_link, horiz_link;
    logic                   need_prev, need_left;
    logic                   row_last, col_last, frame_end;

    always_comb begin : pixel_datapath
        cur_entry  = valid_reg[lab_reg] ? mem_rdata_reg : '0;
        left_lab   = col_rdata_reg;
        lab_ok     = {1'b0, lab_reg}  < n_eff;
        prev_ok    = {1'b0, prev_reg} < n_eff;
        left_ok    = {1'b0, left_lab} < n_eff;
        vert_link  = (row_reg != '0) && lab_ok && prev_ok;
        horiz_link = (col_reg != '0) && lab_ok && left_ok;

        upd_entry = cur_entry;
        if (cur_entry.count == '0) begin
            upd_entry.min_x = col_reg;
            upd_entry.min_y = row_reg;
            upd_entry.max_x = col_reg;
            upd_entry.max_y = row_reg;
        end else begin
            if (col_reg < cur_entry.min_x) upd_entry.min_x = col_reg;
            if (row_reg < cur_entry.min_y) upd_entry.min_y = row_reg;
            if (col_reg > cur_entry.max_x) upd_entry.max_x = col_reg;
            if (row_reg > cur_entry.max_y) upd_entry.max_y = row_reg;
        end
        if (cur_entry.count != COUNT_SAT) begin
            upd_entry.count = cur_entry.count + 1'b1;
        end
        if (vert_link) begin
            upd_entry.adj = upd_entry.adj | label_bit(prev_reg);
        end
        if (horiz_link) begin
            upd_entry.adj = upd_entry.adj | label_bit(left_lab);
        end

        // reverse bits still to set; skip those the own-row or link-prev write already covered
        need_prev = vert_link && (prev_reg != lab_reg);
        need_left = horiz_link && (left_lab != lab_reg)
                    && !(need_prev && (left_lab == prev_reg));

        row_last  = row_reg >= hm1;
        col_last  = col_reg >= wm1;
        frame_end = row_last && col_last;
    end

    // ------------------------------------------------------------------
    // Result datapath (valid in ST_EMIT_LOAD)
    // ------------------------------------------------------------------
    entry_t                     emit_entry;
    logic                       emit_last;
    logic                       out_free;

    logic                       out_valid_reg, out_valid_next;
    logic [LABEL_W-1:0]         out_index_reg, out_index_next;
    logic [COUNT_W-1:0]         out_total_reg, out_total_next;
    logic [COORD_W-1:0]         out_min_x_reg, out_min_x_next;
    logic [COORD_W-1:0]         out_min_y_reg, out_min_y_next;
    logic [COORD_W-1:0]         out_max_x_reg, out_max_x_next;
    logic [COORD_W-1:0]         out_max_y_reg, out_max_y_next;
    logic [MAX_COMPONENTS-1:0]  out_mask_reg,  out_mask_next;
    logic                       out_bad_reg,   out_bad_next;
    logic                       out_last_reg,  out_last_next;

    always_comb begin : result_datapath
        emit_entry = valid_reg[emit_idx_reg] ? mem_rdata_reg : '0;
        emit_last  = {1'b0, emit_idx_reg} == (n_eff - 1'b1);
        out_free   = !out_valid_reg || !out_stall;

        out_index_next = emit_idx_reg;
        out_total_next = emit_entry.count;
        if (emit_entry.count == '0) begin
            // empty component: box from the registers in force now
            out_min_x_next = wm1;
            out_min_y_next = hm1;
            out_max_x_next = '0;
            out_max_y_next = '0;
        end else begin
            out_min_x_next = emit_entry.min_x;
            out_min_y_next = emit_entry.min_y;
            out_max_x_next = emit_entry.max_x;
            out_max_y_next = emit_entry.max_y;
        end
        out_mask_next = emit_entry.adj & ~label_bit(emit_idx_reg);
        out_bad_next  = bad_reg;
        out_last_next = emit_last;
    end

    // ------------------------------------------------------------------
    // FSM: next state
    // ------------------------------------------------------------------
    logic in_accept;
    logic load_out;
    logic do_clear;
    logic [LABEL_W-1:0] link_addr;

    assign in_accept = in_valid && !in_stall;

    always_comb begin : fsm_next_state
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                priority if (need_prev)  state_next = ST_LINK_PREV;
                else if (need_left)      state_next = ST_LINK_LEFT;
                else if (frame_end)      state_next = ST_EMIT_READ;
                else                     state_next = ST_IDLE;
            end
            ST_LINK_PREV: begin
                priority if (need_left_reg) state_next = ST_LINK_LEFT;
                else if (frame_end_reg)     state_next = ST_EMIT_READ;
                else                        state_next = ST_IDLE;
            end
            ST_LINK_LEFT: begin
                state_next = frame_end_reg ? ST_EMIT_READ : ST_IDLE;
            end
            ST_EMIT_READ: begin
                state_next = ST_EMIT_LOAD;
            end
            ST_EMIT_LOAD: begin
                if (out_free) state_next = emit_last ? ST_IDLE : ST_EMIT_READ;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // FSM: outputs (memory strobes, stall, result load)
    // ------------------------------------------------------------------
    always_comb begin : fsm_outputs
        in_stall  = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = lab_reg;
        mem_wdata = upd_entry;
        mem_wmask = '1;
        mem_re    = 1'b0;
        mem_raddr = pixel_label;
        col_we    = 1'b0;
        col_re    = 1'b0;
        load_out  = 1'b0;
        do_clear  = 1'b0;
        link_addr = link_prev_reg;
        unique case (state_reg)
            ST_IDLE: begin
                in_stall = 1'b0;
                mem_re   = in_valid;      // stats + own row of the new label
                col_re   = in_valid;      // left neighbour from the line buffer
            end
            ST_UPDATE: begin
                mem_we = lab_ok;          // full-entry write of the updated row
                col_we = 1'b1;
            end
            ST_LINK_PREV, ST_LINK_LEFT: begin
                if (state_reg == ST_LINK_LEFT) begin
                    link_addr = link_left_reg;
                end
                mem_we        = 1'b1;
                mem_waddr     = link_addr;
                mem_wdata     = '0;
                mem_wdata.adj = label_bit(lab_reg);
                // live row: set one bit; stale row: rewrite as empty plus the bit
                mem_wmask     = valid_reg[link_addr] ? ENTRY_W'(label_bit(lab_reg)) : '1;
            end
            ST_EMIT_READ: begin
                mem_re    = 1'b1;
                mem_raddr = emit_idx_reg;
            end
            ST_EMIT_LOAD: begin
                load_out = out_free;
                do_clear = out_free && emit_last;
            end
            default: begin
                in_stall = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Next values of the control registers
    // ------------------------------------------------------------------
    always_comb begin : control_next
        lab_next       = lab_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        prev_next      = prev_reg;
        bad_next       = bad_reg;
        link_prev_next = link_prev_reg;
        link_left_next = link_left_reg;
        need_left_next = need_left_reg;
        frame_end_next = frame_end_reg;
        valid_next     = valid_reg;
        emit_idx_next  = emit_idx_reg;

        if (in_accept) begin
            lab_next = pixel_label;
        end

        if (state_reg == ST_UPDATE) begin
            if (!lab_ok) bad_next = 1'b1;
            prev_next      = lab_reg;
            link_prev_next = prev_reg;
            link_left_next = left_lab;
            need_left_next = need_left;
            frame_end_next = frame_end;
            if (!row_last) begin
                row_next = row_reg + 1'b1;
            end else begin
                row_next = '0;
                col_next = col_last ? '0 : col_reg + 1'b1;
            end
        end

        if (mem_we) begin
            valid_next[mem_waddr] = 1'b1;
        end

        if (load_out && !emit_last) begin
            emit_idx_next = emit_idx_reg + 1'b1;
        end

        if (do_clear) begin
            valid_next    = '0;
            bad_next      = 1'b0;
            prev_next     = '0;
            emit_idx_next = '0;
        end

        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (!out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            ncomp_reg     <= NCOMP_RESET;
            state_reg     <= ST_IDLE;
            lab_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            prev_reg      <= '0;
            bad_reg       <= 1'b0;
            link_prev_reg <= '0;
            link_left_reg <= '0;
            need_left_reg <= 1'b0;
            frame_end_reg <= 1'b0;
            valid_reg     <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            ncomp_reg     <= ncomp_next;
            state_reg     <= state_next;
            lab_reg       <= lab_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            prev_reg      <= prev_next;
            bad_reg       <= bad_next;
            link_prev_reg <= link_prev_next;
            link_left_reg <= link_left_next;
            need_left_reg <= need_left_next;
            frame_end_reg <= frame_end_next;
            valid_reg     <= valid_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload: loaded only into a free output register
    always_ff @(posedge clk)
    begin
        if (load_out) begin
            out_index_reg <= out_index_next;
            out_total_reg <= out_total_next;
            out_min_x_reg <= out_min_x_next;
            out_min_y_reg <= out_min_y_next;
            out_max_x_reg <= out_max_x_next;
            out_max_y_reg <= out_max_y_next;
            out_mask_reg  <= out_mask_next;
            out_bad_reg   <= out_bad_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign component_index = out_index_reg;
    assign pixel_total     = out_total_reg;
    assign box_min_x       = out_min_x_reg;
    assign box_min_y       = out_min_y_reg;
    assign box_max_x       = out_max_x_reg;
    assign box_max_y       = out_max_y_reg;
    assign neighbour_mask  = out_mask_reg;
    assign bad_label_seen  = out_bad_reg;
    assign last_component  = out_last_reg;

endmodule

`default_nettype wire

// ===== hdl/lmrs_checker.sv =====
// Port-level checker for the label map region statistics unit, bound to the top.
// Depends on label_map_region_statistics_unit_assert.svh for the assertion macros.
`default_nettype none

`include "label_map_region_statistics_unit_assert.svh"

module lmrs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [5:0]  component_index,
    input wire logic [20:0] pixel_total,
    input wire logic [9:0]  box_min_x,
    input wire logic [9:0]  box_min_y,
    input wire logic [9:0]  box_max_x,
    input wire logic [9:0]  box_max_y,
    input wire logic [63:0] neighbour_mask,
    input wire logic        last_component
);

    // stalled result stays put
    `LMRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(component_index) && $stable(pixel_total) && $stable(neighbour_mask))

    // a component never lists itself as neighbour
    `LMRS_ASSERT_NOW(a_own_bit_clear, out_valid, neighbour_mask[component_index] == 1'b0)

    // empty component reports a collapsed max corner; a filled one an ordered box
    `LMRS_ASSERT_NOW(a_empty_box, out_valid && (pixel_total == 21'd0), (box_max_x == 10'd0) && (box_max_y == 10'd0))
    `LMRS_ASSERT_NOW(a_box_order, out_valid && (pixel_total != 21'd0), (box_min_x <= box_max_x) && (box_min_y <= box_max_y))

    // results follow in label order within a frame
    `LMRS_ASSERT_NOW(a_index_step, out_valid && $past(out_valid && !out_stall && !last_component), component_index == ($past(component_index) + 6'd1))

endmodule

bind label_map_region_statistics_unit lmrs_checker u_lmrs_checker (.*);

`default_nettype wire
